// ===== hdl/osbr_pkg.sv =====
// Shared types, operation codes and frame constants for the serial byte receiver.
package osbr_pkg;

   // Operation codes carried on the request tuser field
   typedef enum logic [2:0] {
      OP_ARM   = 3'd0,
      OP_START = 3'd1,
      OP_TICK  = 3'd2,
      OP_IDLE  = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   localparam int BUF_DEPTH_DEFAULT = 8;

   localparam logic [4:0]  START_TICK     = 5'd1;
   localparam logic [4:0]  LAST_DATA_TICK = 5'd19;
   localparam logic [4:0]  STOP_TICK      = 5'd20;
   localparam logic [7:0]  TOP_BIT        = 8'h80;
   localparam logic [7:0]  TIMEOUT_RESET  = 8'd200;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;

   // One word handed from the input register to the frame logic
   typedef struct packed {
      op_type     op;
      logic       line;
      logic [7:0] read_value;
   } step_type;

   // One result word
   typedef struct packed {
      logic [7:0]  read_data;
      logic        rx_done;
      logic        frame_error;
      logic [15:0] received_count;
      logic        byte_stored;
      logic [7:0]  byte_value;
      logic        byte_valid;
   } result_type;

endpackage

// ===== hdl/osbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module osbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/osbr_frame.sv =====
// Frame state, bit sampling, byte count and idle timeout for one word per cycle while go is high.
module osbr_frame import osbr_pkg::*; #(
   parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       go,
   input  step_type                                   step,
   input  logic [7:0]                                 timeout_limit,
   output result_type                                 result,
   output logic                                       mem_we,
   output logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] mem_addr,
   output logic [7:0]                                 mem_data
);

   localparam int ADDR_W = BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1;

   logic [4:0]  tick_ff, tick_in, tick_next;
   logic [7:0]  shift_ff, shift_in;
   logic        running_ff, running_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  idle_ff, idle_in;

   // Compute next state and the result word
   always_comb begin
      tick_in    = tick_ff;
      shift_in   = shift_ff;
      running_in = running_ff;
      total_in   = total_ff;
      idle_in    = idle_ff;
      tick_next  = tick_ff + 5'd1;
      result     = '0;
      mem_we     = 1'b0;
      mem_addr   = ADDR_W'(total_ff);
      mem_data   = shift_ff;

      unique case (step.op)
         OP_ARM: begin
            idle_in    = '0;
            total_in   = '0;
            tick_in    = '0;
            running_in = 1'b0;
         end
         OP_START: begin
            if (!running_ff) begin
               running_in = 1'b1;
               tick_in    = '0;
            end
         end
         OP_TICK: begin
            if (running_ff) begin
               idle_in = 8'd1;
               tick_in = tick_next;
               priority if (tick_next == START_TICK) begin
                  if (!step.line) begin
                     shift_in = '0;
                  end
               end else if (tick_next < LAST_DATA_TICK) begin
                  // shift in a data bit on odd ticks, LSB first
                  if (tick_next[0]) begin
                     shift_in = (shift_ff >> 1) | (step.line ? TOP_BIT : 8'h00);
                  end
               end else if (tick_next == STOP_TICK) begin
                  running_in = 1'b0;
                  tick_in    = '0;
                  shift_in   = '0;
                  if (step.line) begin
                     result.byte_valid = 1'b1;
                     result.byte_value = shift_ff;
                     if (total_ff < 16'(BUF_DEPTH)) begin
                        mem_we             = 1'b1;
                        result.byte_stored = 1'b1;
                     end
                     if (total_ff != COUNT_MAX) begin
                        total_in = total_ff + 16'd1;
                     end
                  end else begin
                     result.frame_error = 1'b1;
                  end
               end else begin
                  // tick 19 and ticks past 20: count only
               end
            end
         end
         OP_IDLE: begin
            if (idle_ff != '0) begin
               if (idle_ff >= timeout_limit) begin
                  running_in     = 1'b0;
                  idle_in        = '0;
                  result.rx_done = 1'b1;
               end else begin
                  idle_in = idle_ff + 8'd1;
               end
            end
         end
         OP_READ: begin
            result.read_data = step.read_value;
         end
         default: begin
         end
      endcase

      result.received_count = total_in;
   end

   // Advance state when the word leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         shift_ff   <= '0;
         running_ff <= 1'b0;
         total_ff   <= '0;
         idle_ff    <= '0;
      end else if (go) begin
         tick_ff    <= tick_in;
         shift_ff   <= shift_in;
         running_ff <= running_in;
         total_ff   <= total_in;
         idle_ff    <= idle_in;
      end
   end

endmodule

// ===== hdl/oversampled_serial_byte_receiver.sv =====
// Top level of the oversampled serial byte receiver: channels, staging and buffer.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser op, tdata samples and read index
//   rsp      out        rsp_tvalid/rsp_tready  tdata one result word per request word
//   csr      in         csr_valid/csr_ready    csr_data idle timeout limit
//
// From request accept to result valid a word passes an input register
// (buffer read issued at accept) and a result register.
// One word per cycle is accepted while the result side does not stall; the rate is set by the single frame-logic stage.
// Reset clears all control and frame state; the byte buffer is not cleared.
// A stalled result holds the input stage, which then holds req_tready low.
module oversampled_serial_byte_receiver import osbr_pkg::*; #(
   parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_USER_W-1:0] req_tuser,  // [2:0] op
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] line_samples, [6:4] read_index
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] byte_valid, [8:1] byte_value, [9] byte_stored, [25:10] received_count,
   // [26] frame_error, [27] rx_done, [35:28] read_data
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);

   localparam int ADDR_W = BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1;

   logic             req_accept, s1_advance;
   logic             s1_valid_ff;
   logic [2:0]       s1_op_ff;
   logic             s1_line_ff;
   logic [2:0]       s1_idx_ff;
   logic             byp_hit_ff, byp_hit_in;
   logic [7:0]       byp_data_ff;
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [7:0]       limit_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]       ram_rd_data;
   logic [7:0]       read_value;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]       mem_data;
   step_type         step;
   result_type       result;

   // Handshake: input stage moves on when the result register is free or drains
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Forward a buffer write that lands on the address being read this edge
   assign rd_addr    = ADDR_W'(req_tdata[6:4]);
   assign byp_hit_in = mem_we && s1_advance && (mem_addr == rd_addr);

   // Hold the timeout limit
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_tuser;
         s1_line_ff  <= |req_tdata[3:0];
         s1_idx_ff   <= req_tdata[6:4];
         byp_hit_ff  <= byp_hit_in;
         byp_data_ff <= mem_data;
      end
   end

   osbr_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_buf (
      .clock  (clock),
      .wr_en  (mem_we && s1_advance),
      .wr_addr(mem_addr),
      .wr_data(mem_data),
      .rd_en  (req_accept),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // Drop reads beyond the buffer
   always_comb begin
      read_value = '0;
      if (9'(s1_idx_ff) < 9'(BUF_DEPTH)) begin
         read_value = byp_hit_ff ? byp_data_ff : ram_rd_data;
      end
   end

   assign step.op         = op_type'(s1_op_ff);
   assign step.line       = s1_line_ff;
   assign step.read_value = read_value;

   osbr_frame #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_frame (
      .clock        (clock),
      .reset        (reset),
      .go           (s1_advance),
      .step         (step),
      .timeout_limit(limit_ff),
      .result       (result),
      .mem_we       (mem_we),
      .mem_addr     (mem_addr),
      .mem_data     (mem_data)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= RSP_DATA_W'(result);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_stored_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[9] || rsp_tdata[0]))
      else $error("byte stored without a valid byte");

   a_valid_excludes_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[26]))
      else $error("good byte and frame error in one word");

   a_arm_clears_count: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_op_ff == OP_ARM) |=> (rsp_tdata[25:10] == 16'd0))
      else $error("arm did not clear the byte count");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty input stage not ready");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the oversampled serial byte receiver.
module tb import osbr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CLK_PERIOD  = 10;
   localparam int         DEPTH       = BUF_DEPTH_DEFAULT;
   localparam int         LONG_HOLD   = 300;
   localparam int         TAIL_CYCLES = 12;
   localparam int         PHASE_WORDS = 350;
   localparam logic [2:0] OP_RSVD_HI  = 3'd7;

   // One request word as queued for the feeder
   typedef struct {
      logic [2:0] op;
      logic [3:0] samples;
      logic [2:0] ridx;
      bit         typed;
      result_type want;
   } req_word_type;

   // One row of the directed plan
   typedef struct {
      req_word_type word;
      int           reps;
   } plan_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // [2:0] op
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [3:0] line_samples, [6:4] read_index
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] byte_valid, [8:1] byte_value, [9] byte_stored, [25:10] received_count,
   // [26] frame_error, [27] rx_done, [35:28] read_data
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_data   = '0;

   // Receiver state as predicted
   logic [4:0]  rx_tick    = '0;
   logic [7:0]  rx_shift   = '0;
   logic        rx_running = 1'b0;
   logic [15:0] rx_total   = '0;
   logic [7:0]  rx_idle    = '0;
   logic [7:0]  idle_limit = TIMEOUT_RESET;
   logic [7:0]  byte_mem [DEPTH];
   bit   [DEPTH-1:0] mem_written = '0;

   req_word_type req_words[$];
   result_type   pending_results[$];
   plan_row_type plan[$];
   int           queued_words   = 0;
   int           mismatch_count = 0;
   int           src_gap_pct    = 0;
   int           sink_stall_pct = 0;
   bit           long_hold_req  = 1'b0;

   oversampled_serial_byte_receiver #(.BUF_DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Advance the predicted receiver by one word and return its result word
   function automatic result_type rx_model_step(input logic [2:0] op,
                                                input logic [3:0] samples,
                                                input logic [2:0] ridx);
      result_type r;
      logic       line_hi;
      r       = '0;
      line_hi = |samples;
      case (op)
         OP_ARM: begin
            rx_idle    = '0;
            rx_total   = '0;
            rx_tick    = '0;
            rx_running = 1'b0;
         end
         OP_START: begin
            if (!rx_running) begin
               rx_running = 1'b1;
               rx_tick    = '0;
            end
         end
         OP_TICK: begin
            if (rx_running) begin
               rx_idle = 8'd1;
               rx_tick = rx_tick + 5'd1;
               if (rx_tick == START_TICK) begin
                  if (!line_hi) rx_shift = '0;
               end else if (rx_tick < LAST_DATA_TICK) begin
                  if (rx_tick[0]) rx_shift = {line_hi, rx_shift[7:1]};
               end else if (rx_tick == STOP_TICK) begin
                  rx_running = 1'b0;
                  rx_tick    = '0;
                  if (line_hi) begin
                     r.byte_valid = 1'b1;
                     r.byte_value = rx_shift;
                     if (rx_total < DEPTH) begin
                        byte_mem[rx_total[2:0]]    = rx_shift;
                        mem_written[rx_total[2:0]] = 1'b1;
                        r.byte_stored              = 1'b1;
                     end
                     if (rx_total != COUNT_MAX) rx_total = rx_total + 16'd1;
                  end else begin
                     r.frame_error = 1'b1;
                  end
                  rx_shift = '0;
               end
            end
         end
         OP_IDLE: begin
            if (rx_idle != 0) begin
               if (rx_idle >= idle_limit) begin
                  rx_running = 1'b0;
                  rx_idle    = '0;
                  r.rx_done  = 1'b1;
               end else begin
                  rx_idle = rx_idle + 8'd1;
               end
            end
         end
         OP_READ: begin
            if (ridx < DEPTH) r.read_data = byte_mem[ridx];
         end
         default: ;
      endcase
      r.received_count = rx_total;
      return r;
   endfunction

   function automatic result_type make_result(input logic valid, input logic [7:0] value,
                                              input logic stored, input logic [15:0] count,
                                              input logic ferr, input logic done,
                                              input logic [7:0] rdata);
      result_type r;
      r.byte_valid     = valid;
      r.byte_value     = value;
      r.byte_stored    = stored;
      r.received_count = count;
      r.frame_error    = ferr;
      r.rx_done        = done;
      r.read_data      = rdata;
      return r;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Pick a buffer entry that already holds a byte, -1 if none does
   function automatic int pick_read_index();
      int slots[$];
      for (int i = 0; i < DEPTH; i++)
         if (mem_written[i]) slots.push_back(i);
      if (slots.size() == 0) return -1;
      return slots[$urandom_range(0, slots.size() - 1)];
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_word(input logic [2:0] op, input logic [3:0] samples,
                             input logic [2:0] ridx);
      req_word_type w;
      w.op      = op;
      w.samples = samples;
      w.ridx    = ridx;
      w.typed   = 1'b0;
      w.want    = '0;
      req_words.push_back(w);
      queued_words++;
   endtask

   task automatic queue_read();
      int idx;
      idx = pick_read_index();
      if (idx >= 0) queue_word(OP_READ, 4'($urandom), 3'(idx));
   endtask

   task automatic queue_noise();
      logic [2:0] op;
      op = 3'($urandom_range(0, 7));
      if (op == OP_READ) queue_read();
      else queue_word(op, 4'($urandom), 3'($urandom));
   endtask

   // Mostly well-formed frame with random content, now and then a stray word inside
   task automatic queue_frame();
      logic [7:0] data;
      logic [3:0] s;
      bit         bad_stop;
      bit         high_start;
      data       = 8'($urandom);
      bad_stop   = ($urandom_range(0, 99) < 15);
      high_start = ($urandom_range(0, 99) < 10);
      queue_word(OP_START, 4'($urandom), 3'($urandom));
      for (int t = 1; t <= 20; t++) begin
         if ($urandom_range(0, 99) < 4) begin
            case ($urandom_range(0, 2))
               0: queue_word(OP_IDLE, 4'($urandom), 3'($urandom));
               1: queue_read();
               default: queue_word(OP_START, 4'($urandom), 3'($urandom));
            endcase
         end
         if (t == 1) s = high_start ? 4'($urandom_range(1, 15)) : 4'h0;
         else if (t == 20) s = bad_stop ? 4'h0 : 4'($urandom_range(1, 15));
         else if (t[0] && t <= 17) s = data[(t - 3) / 2] ? 4'($urandom_range(1, 15)) : 4'h0;
         else s = 4'($urandom);
         queue_word(OP_TICK, s, 3'($urandom));
      end
   endtask

   // Start edge followed by zero to 25 ticks
   task automatic queue_broken_frame();
      int n;
      n = $urandom_range(0, 25);
      queue_word(OP_START, 4'($urandom), 3'($urandom));
      repeat (n)
         queue_word(OP_TICK, ($urandom_range(0, 9) < 3) ? 4'h0 : 4'($urandom), 3'($urandom));
   endtask

   task automatic queue_idle_run();
      repeat ($urandom_range(1, int'(idle_limit) + 2))
         queue_word(OP_IDLE, 4'($urandom), 3'($urandom));
   endtask

   // Hold until every queued word is accepted and every result has come back
   task automatic drain();
      while (req_words.size() != 0 || pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout_limit(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      idle_limit = value;
   endtask

   task automatic add_row(input logic [2:0] op, input logic [3:0] samples,
                          input logic [2:0] ridx, input int reps, input bit typed,
                          input result_type want);
      plan_row_type row;
      row.word.op      = op;
      row.word.samples = samples;
      row.word.ridx    = ridx;
      row.word.typed   = typed;
      row.word.want    = want;
      row.reps         = reps;
      plan.push_back(row);
   endtask

   task automatic run_random_phase(input int words);
      int stop_at;
      int pick;
      stop_at = queued_words + words;
      queue_word(OP_ARM, 4'($urandom), 3'($urandom));
      while (queued_words < stop_at) begin
         while (req_words.size() > 8) @(posedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 55) queue_frame();
         else if (pick < 65) queue_broken_frame();
         else if (pick < 73) queue_idle_run();
         else if (pick < 80) repeat ($urandom_range(1, 4)) queue_read();
         else if (pick < 85) queue_word(OP_ARM, 4'($urandom), 3'($urandom));
         else repeat ($urandom_range(1, 5)) queue_noise();
      end
      drain();
   endtask

   // Feed request words, predict each one at the edge that accepts it
   initial begin : request_feed
      req_word_type w;
      result_type   predicted;
      int           gap_left;
      gap_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (req_words.size() == 0 || gap_left > 0) begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
            @(posedge clock);
         end else begin
            w = req_words[0];
            req_tvalid <= 1'b1;
            req_tuser  <= w.op;
            req_tdata  <= {1'b0, w.ridx, w.samples};
            do @(posedge clock); while (!req_tready);
            w         = req_words.pop_front();
            predicted = rx_model_step(w.op, w.samples, w.ridx);
            pending_results.push_back(w.typed ? w.want : predicted);
            if ($urandom_range(0, 99) < src_gap_pct) gap_left = pick_gap();
         end
      end
   end

   // Result side ready, with random stalls and one long hold-off on request
   initial begin : result_sink
      int len;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            len           = LONG_HOLD;
         end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            len = pick_gap();
         end else begin
            len = 0;
         end
         if (len > 0) begin
            rsp_tready <= 1'b0;
            repeat (len) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each result word against the oldest prediction
   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result word 0x%h with none pending", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (got.byte_valid !== want.byte_valid)
               report_mismatch($sformatf("byte_valid %b, want %b",
                                         got.byte_valid, want.byte_valid));
            if (got.byte_value !== want.byte_value)
               report_mismatch($sformatf("byte_value 0x%h, want 0x%h",
                                         got.byte_value, want.byte_value));
            if (got.byte_stored !== want.byte_stored)
               report_mismatch($sformatf("byte_stored %b, want %b",
                                         got.byte_stored, want.byte_stored));
            if (got.received_count !== want.received_count)
               report_mismatch($sformatf("received_count %0d, want %0d",
                                         got.received_count, want.received_count));
            if (got.frame_error !== want.frame_error)
               report_mismatch($sformatf("frame_error %b, want %b",
                                         got.frame_error, want.frame_error));
            if (got.rx_done !== want.rx_done)
               report_mismatch($sformatf("rx_done %b, want %b", got.rx_done, want.rx_done));
            if (got.read_data !== want.read_data)
               report_mismatch($sformatf("read_data 0x%h, want 0x%h",
                                         got.read_data, want.read_data));
         end
      end
   end

   // Hard stop for a hung run
   initial begin : watchdog
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : main_flow
      result_type zero;
      zero = make_result(1'b0, 8'h00, 1'b0, 16'd0, 1'b0, 1'b0, 8'h00);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored words, start edges, then one good all-ones frame and its read-back
      add_row(OP_TICK,    4'hF,    3'd0, 1,  1'b1, zero);
      add_row(OP_IDLE,    4'hF,    3'd7, 1,  1'b1, zero);
      add_row(OP_RSVD_HI, 4'hF,    3'd7, 1,  1'b1, zero);
      add_row(OP_ARM,     4'h0,    3'd0, 1,  1'b1, zero);
      add_row(OP_START,   4'h0,    3'd0, 1,  1'b1, zero);
      add_row(OP_START,   4'hF,    3'd7, 1,  1'b1, zero);
      add_row(OP_TICK,    4'h0,    3'd0, 1,  1'b1, zero);
      add_row(OP_TICK,    4'b1000, 3'd0, 18, 1'b0, zero);
      add_row(OP_TICK,    4'b0001, 3'd0, 1,  1'b1,
              make_result(1'b1, 8'hFF, 1'b1, 16'd1, 1'b0, 1'b0, 8'h00));
      add_row(OP_READ,    4'h0,    3'd0, 1,  1'b1,
              make_result(1'b0, 8'h00, 1'b0, 16'd1, 1'b0, 1'b0, 8'hFF));
      src_gap_pct    = 20;
      sink_stall_pct = 20;
      foreach (plan[i]) begin
         repeat (plan[i].reps) begin
            req_words.push_back(plan[i].word);
            queued_words++;
         end
      end
      drain();

      // Reset value of the timeout, light idling on both sides
      src_gap_pct    = 15;
      sink_stall_pct = 15;
      run_random_phase(PHASE_WORDS);

      // Shortest timeout, back-to-back with no idling
      write_timeout_limit(8'd1);
      src_gap_pct    = 0;
      sink_stall_pct = 0;
      run_random_phase(PHASE_WORDS);

      // Longest timeout; the result side holds off while requests keep coming
      write_timeout_limit(8'd255);
      src_gap_pct    = 0;
      sink_stall_pct = 25;
      long_hold_req  = 1'b1;
      run_random_phase(PHASE_WORDS);

      // Short random timeout, heavy idling on both sides
      write_timeout_limit(8'($urandom_range(2, 30)));
      src_gap_pct    = 35;
      sink_stall_pct = 35;
      run_random_phase(PHASE_WORDS);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/osbr_pkg.sv
hdl/osbr_ram.sv
hdl/osbr_frame.sv
hdl/oversampled_serial_byte_receiver.sv
dv/tb.sv
